FILE: design/ldmc_pkg.sv
`timescale 1ns / 1ps

package ldmc_pkg;

  // Control word layout
  localparam logic [7:0] CTRL_DEFAULT = 8'h4f;
  localparam logic [7:0] CTRL_ENABLE  = 8'h01;
  localparam logic [7:0] CTRL_SENSORS = 8'h0e;
  localparam logic [7:0] CTRL_DRY     = 8'h20;

  localparam int SENSOR_CNT = 3;

  // Register map
  localparam int          CFG_ADDR_W       = 3;
  localparam logic [0:0]  REG_INIT_CONTROL = 1'b0;

  // Payload widths on the stream ports
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 24;

  // Reference sensor state codes
  typedef enum logic [1:0] {
    REF_DISABLED = 2'd0,
    REF_DRY      = 2'd1,
    REF_WET      = 2'd2
  } ref_state_t;

  // Sensor state codes
  typedef enum logic [1:0] {
    SNS_DISABLED = 2'd0,
    SNS_DRY      = 2'd1,
    SNS_WET      = 2'd2,
    SNS_INVALID  = 2'd3
  } sns_state_t;

  // Transition codes
  typedef enum logic [2:0] {
    TR_REF_WET     = 3'd0,
    TR_SENSORS_WET = 3'd1,
    TR_WET_SPUR    = 3'd2,
    TR_REF_DRIED   = 3'd3,
    TR_ALL_DRY     = 3'd4,
    TR_STILL_WET   = 3'd5,
    TR_DRY_SPUR    = 3'd6
  } transition_t;

  // One interrupt snapshot
  typedef struct packed {
    logic       fuse_raw;
    logic [2:0] sensor_hits;
    logic       reference_wet;
  } event_t;

  // One classification result
  typedef struct packed {
    transition_t transition;
    logic        fuse_blown;
    sns_state_t  sensor2_state;
    sns_state_t  sensor1_state;
    sns_state_t  sensor0_state;
    ref_state_t  reference_state;
    logic        old_enable;
    logic [7:0]  new_control;
  } result_t;

endpackage

FILE: design/liquid_detect_mode_controller.sv
`timescale 1ns / 1ps

// Liquid-detect mode controller. Each transfer on the in_ channel is one
// interrupt snapshot; each yields exactly one result on the out_ channel after
// passing through the input register, then the result register. With
// out_tready high a new snapshot can be taken every cycle; while a finished
// result waits for out_tready, the input register takes one more snapshot and
// in_tready then stays low until the result leaves. The 8-bit control word
// lives in one register that is updated as each snapshot moves from the input
// register to the result register, so back-to-back snapshots see each other's
// effect. Writing initial_control (offset 0x0) over the APB port also reloads
// the control word; write it only when no snapshot is in flight. After reset
// both hold 0x4f.
module liquid_detect_mode_controller (
  input  logic                               clk,
  input  logic                               rst_n,
  // Snapshot channel
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [0] reference_wet, [3:1] sensor_hits, [4] fuse_raw, [7:5] zero
  input  logic [ldmc_pkg::IN_TDATA_W-1:0]    in_tdata,
  // Result channel
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [7:0] new_control, [8] old_enable, [10:9] reference_state,
  // [12:11] sensor0_state, [14:13] sensor1_state, [16:15] sensor2_state,
  // [17] fuse_blown, [20:18] transition, [23:21] zero
  output logic [ldmc_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // Configuration port
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [ldmc_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [31:0]                        cfg_pwdata,
  output logic [31:0]                        cfg_prdata,
  output logic                               cfg_pready
);

  logic               in_valid_r;
  ldmc_pkg::event_t   in_evt_r;
  logic               out_valid_r;
  ldmc_pkg::result_t  out_res_r;
  logic [7:0]         init_ctrl_r;
  logic [7:0]         ctrl_r;
  logic [7:0]         ctrl_nxt;
  ldmc_pkg::result_t  res;
  logic               advance;
  logic               cfg_wr;
  logic               cfg_hit;

  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[ldmc_pkg::CFG_ADDR_W-1] == ldmc_pkg::REG_INIT_CONTROL);
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_hit;
  assign cfg_prdata = cfg_hit ? {24'h000000, init_ctrl_r} : 32'h00000000;

  // Move the held snapshot forward when the result slot frees up
  assign advance   = in_valid_r & (~out_valid_r | out_tready);
  assign in_tready = rst_n & (~in_valid_r | advance);

  ldmc_eval u_eval (
    .control_word    (ctrl_r),
    .initial_control (init_ctrl_r),
    .evt             (in_evt_r),
    .res             (res)
  );

  // Pick the next control word: config reload, event update, or hold
  always_comb begin
    ctrl_nxt = ctrl_r;
    if (cfg_wr) begin
      ctrl_nxt = cfg_pwdata[7:0];
    end else if (advance) begin
      ctrl_nxt = res.new_control;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      init_ctrl_r <= ldmc_pkg::CTRL_DEFAULT;
      ctrl_r      <= ldmc_pkg::CTRL_DEFAULT;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr) begin
        init_ctrl_r <= cfg_pwdata[7:0];
      end
      ctrl_r <= ctrl_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_evt_r <= ldmc_pkg::event_t'(in_tdata[4:0]);
    end
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_res_r};

endmodule

FILE: design/ldmc_eval.sv
`timescale 1ns / 1ps

module ldmc_eval (
  input  logic [7:0]       control_word,
  input  logic [7:0]       initial_control,
  input  ldmc_pkg::event_t evt,
  output ldmc_pkg::result_t res
);

  logic                    en;
  logic                    ref_wet_cls;
  logic [7:0]              hit_mask;
  logic [7:0]              wet_base;
  logic [7:0]              cleared;
  logic [7:0]              next_word;
  ldmc_pkg::transition_t   code;
  ldmc_pkg::sns_state_t    sens [ldmc_pkg::SENSOR_CNT];
  ldmc_pkg::ref_state_t    ref_state;

  assign en          = control_word[0];
  assign ref_wet_cls = en & evt.reference_wet;
  assign hit_mask    = {4'b0000, evt.sensor_hits, 1'b0};
  assign wet_base    = (control_word | ldmc_pkg::CTRL_DRY | ldmc_pkg::CTRL_ENABLE)
                       & ~ldmc_pkg::CTRL_SENSORS;
  assign cleared     = control_word & ~hit_mask;

  // Classify the reference from the old enable bit
  always_comb begin
    if (!en) begin
      ref_state = ldmc_pkg::REF_DISABLED;
    end else if (evt.reference_wet) begin
      ref_state = ldmc_pkg::REF_WET;
    end else begin
      ref_state = ldmc_pkg::REF_DRY;
    end
  end

  // Classify each sensor; a wet reference invalidates enabled sensors
  always_comb begin
    for (int i = 0; i < ldmc_pkg::SENSOR_CNT; i++) begin
      if (!(en && control_word[i + 1])) begin
        sens[i] = ldmc_pkg::SNS_DISABLED;
      end else if (ref_wet_cls) begin
        sens[i] = ldmc_pkg::SNS_INVALID;
      end else if (evt.sensor_hits[i]) begin
        sens[i] = ldmc_pkg::SNS_WET;
      end else begin
        sens[i] = ldmc_pkg::SNS_DRY;
      end
    end
  end

  // Apply the wet-to-dry and dry-to-wet rules
  always_comb begin
    next_word = control_word;
    code      = ldmc_pkg::TR_WET_SPUR;
    if (!control_word[5]) begin
      if (evt.reference_wet) begin
        next_word = wet_base;
        code      = ldmc_pkg::TR_REF_WET;
      end else if (evt.sensor_hits != 3'b000) begin
        next_word = wet_base | hit_mask;
        code      = ldmc_pkg::TR_SENSORS_WET;
      end
    end else begin
      code = ldmc_pkg::TR_DRY_SPUR;
      if (evt.reference_wet) begin
        next_word = initial_control;
        code      = ldmc_pkg::TR_REF_DRIED;
      end else if (evt.sensor_hits != 3'b000) begin
        if ((cleared & ldmc_pkg::CTRL_SENSORS) == 8'h00) begin
          next_word = initial_control & ~ldmc_pkg::CTRL_DRY;
          code      = ldmc_pkg::TR_ALL_DRY;
        end else begin
          next_word = cleared;
          code      = ldmc_pkg::TR_STILL_WET;
        end
      end
    end
  end

  // Assemble the result
  always_comb begin
    res.new_control     = next_word;
    res.old_enable      = en;
    res.reference_state = ref_state;
    res.sensor0_state   = sens[0];
    res.sensor1_state   = sens[1];
    res.sensor2_state   = sens[2];
    res.fuse_blown      = ~evt.fuse_raw;
    res.transition      = code;
  end

endmodule
